[hw/rtl/u16550_pkg.sv]
// types, register offsets and bit constants of the 16550a register model
package u16550_pkg;

    // item commands
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_HOST_RX = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // register offsets inside the eight-port window
    localparam logic [2:0] OFF_DATA = 3'd0;
    localparam logic [2:0] OFF_IER  = 3'd1;
    localparam logic [2:0] OFF_IIR  = 3'd2;
    localparam logic [2:0] OFF_LCR  = 3'd3;
    localparam logic [2:0] OFF_MCR  = 3'd4;
    localparam logic [2:0] OFF_LSR  = 3'd5;
    localparam logic [2:0] OFF_MSR  = 3'd6;
    localparam logic [2:0] OFF_SCR  = 3'd7;

    localparam int WINDOW_SIZE = 8;

    // fixed register values
    localparam logic [7:0] MSR_IDLE      = 8'hb0;
    localparam logic [7:0] IER_MASK      = 8'h0f;
    localparam logic [7:0] IIR_FIFO_BITS = 8'hc0;
    localparam logic [7:0] LSR_TX_EMPTY  = 8'h60;
    localparam logic [3:0] IIR_RX_DATA   = 4'h4;
    localparam logic [3:0] IIR_THR_EMPTY = 4'h2;
    localparam logic [3:0] IIR_NONE      = 4'h1;

    // control bit positions
    localparam int LCR_DLAB     = 7;
    localparam int MCR_IRQ_GATE = 3;
    localparam int MCR_LB       = 4;
    localparam int IER_RX       = 0;
    localparam int IER_THR      = 1;
    localparam int FCR_FIFO_ON  = 0;
    localparam int FCR_RX_CLEAR = 1;

    // result queue in front of the output port
    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = 2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] port;
        logic [7:0]  wdata;
        logic        first_of_access;
    } item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_out;
        logic       port_error;
        logic       rx_accepted;
    } result_t;

endpackage

[hw/rtl/u16550_ram.sv]
// generic single-write, single-read ram with registered read data
module u16550_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/u16550_out_queue.sv]
// three-entry result queue that decouples the output stall from the input side
module u16550_out_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  u16550_pkg::result_t      push_data,
    output logic                     result_valid,
    input  logic                     result_stall,
    output u16550_pkg::result_t      result,
    output logic [1:0]               level
);

    u16550_pkg::result_t entry_reg [u16550_pkg::OQ_DEPTH];
    logic [u16550_pkg::OQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [u16550_pkg::OQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0]                      count_reg, count_next;
    logic                            pop;

    function automatic logic [u16550_pkg::OQ_PTR_W-1:0] ptr_inc(
        input logic [u16550_pkg::OQ_PTR_W-1:0] p
    );
        logic [u16550_pkg::OQ_PTR_W-1:0] r;
        if (p == u16550_pkg::OQ_PTR_W'(u16550_pkg::OQ_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign result_valid = (count_reg != 2'd0);
    assign pop          = result_valid && !result_stall;
    assign result       = entry_reg[rd_ptr_reg];
    assign level        = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/uart_16550a_register_model.sv]
// top level of the 16550a uart register model with its receive fifo memory
//
// usage:
//   item channel (item_valid / item_stall / item) carries bus writes, bus reads
//   and bytes received from the host line; each accepted beat yields exactly one
//   beat on the result channel (result_valid / result_stall / result).
//   all control registers update at the edge that accepts the item, so the next
//   item sees them at once. received bytes live in a synchronous ram; a read of
//   rbr pops the head entry and its data arrives from the ram in the next cycle.
//   a result passes through the ram read stage and then the result queue.
//   throughput: one item per cycle while item_stall is low, set by the single ram
//   read port; the registered ram read is absorbed by the result stage.
//   a three-entry result queue sits in front of the output, so items keep being
//   accepted while a result waits; item_stall rises only once the queue and the
//   ram read stage together hold three results, and drops as they drain.
//   reset clears all control registers, fifo pointers and the result queue;
//   ram contents are not cleared since only counted entries are ever read.
module uart_16550a_register_model #(
    parameter int RX_DEPTH        = 64,
    parameter int LOOP_FIFO_DEPTH = 16,
    parameter int BASE_PORT       = 1016
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  u16550_pkg::item_t     item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output u16550_pkg::result_t   result
);

    localparam int HEAD_W = $clog2(RX_DEPTH);
    localparam int FILL_W = $clog2(RX_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;

    // control state
    logic [HEAD_W-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [3:0]        ier_reg, ier_next;
    logic              fifo_en_reg, fifo_en_next;
    logic [7:0]        lcr_reg, lcr_next;
    logic [7:0]        mcr_reg, mcr_next;
    logic [7:0]        dll_reg, dll_next;
    logic [7:0]        dlm_reg, dlm_next;
    logic [7:0]        scr_reg, scr_next;
    logic              thre_reg, thre_next;
    logic              irq_reg, irq_next;

    // ram read stage
    logic                s1_valid_reg;
    logic                s1_pop_reg, s1_pop_next;
    u16550_pkg::result_t s1_result_reg, s1_result_next;
    u16550_pkg::result_t s1_result_irq;
    u16550_pkg::result_t s1_result_full;

    logic              accept;
    logic [1:0]        oq_level;
    logic [2:0]        occupancy;
    logic [15:0]       offset16;
    logic              in_window;
    logic [2:0]        off;
    logic              dlab;
    logic [7:0]        ident;
    logic [SUM_W-1:0]  tail_sum;
    logic [HEAD_W-1:0] tail;
    logic              push;
    logic              pop;
    logic [7:0]        push_byte;
    logic [7:0]        ram_rd_data;
    logic              loop_room;
    logic              irq_pending;

    assign occupancy  = 3'(oq_level) + 3'(s1_valid_reg);
    assign item_stall = (occupancy >= 3'(u16550_pkg::OQ_DEPTH));
    assign accept     = item_valid && !item_stall;

    assign offset16  = item.port - 16'(BASE_PORT);
    assign in_window = (item.port >= 16'(BASE_PORT)) &&
                       (offset16 < 16'(u16550_pkg::WINDOW_SIZE));
    assign off       = offset16[2:0];
    assign dlab      = lcr_reg[u16550_pkg::LCR_DLAB];

    // tail = (head + fill) mod depth, the sum stays below twice the depth
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign tail     = (tail_sum >= SUM_W'(RX_DEPTH)) ?
                      HEAD_W'(tail_sum - SUM_W'(RX_DEPTH)) : HEAD_W'(tail_sum);

    assign loop_room = ({{(32 - FILL_W){1'b0}}, fill_reg} < 32'(LOOP_FIFO_DEPTH)) &&
                       (fill_reg < FILL_W'(RX_DEPTH));

    // interrupt identification from the current state
    always_comb
    begin
        ident[7:4] = fifo_en_reg ? u16550_pkg::IIR_FIFO_BITS[7:4] : 4'h0;
        if (ier_reg[u16550_pkg::IER_RX] && (fill_reg != '0))
        begin
            ident[3:0] = u16550_pkg::IIR_RX_DATA;
        end
        else if (ier_reg[u16550_pkg::IER_THR] && thre_reg)
        begin
            ident[3:0] = u16550_pkg::IIR_THR_EMPTY;
        end
        else
        begin
            ident[3:0] = u16550_pkg::IIR_NONE;
        end
    end

    always_comb
    begin
        head_next      = head_reg;
        fill_next      = fill_reg;
        ier_next       = ier_reg;
        fifo_en_next   = fifo_en_reg;
        lcr_next       = lcr_reg;
        mcr_next       = mcr_reg;
        dll_next       = dll_reg;
        dlm_next       = dlm_reg;
        scr_next       = scr_reg;
        thre_next      = thre_reg;
        push           = 1'b0;
        push_byte      = item.wdata;
        pop            = 1'b0;
        s1_pop_next    = 1'b0;
        s1_result_next = '0;

        unique case (item.cmd)
            u16550_pkg::CMD_WRITE:
            begin
                if (!in_window)
                begin
                    s1_result_next.port_error = 1'b1;
                end
                else if ((off == u16550_pkg::OFF_DATA) && !dlab)
                begin
                    if (mcr_reg[u16550_pkg::MCR_LB])
                    begin
                        push = loop_room;
                    end
                    else
                    begin
                        s1_result_next.tx_valid = 1'b1;
                        s1_result_next.tx_byte  = item.wdata;
                    end
                    thre_next = 1'b1;
                end
                else if (item.first_of_access)
                begin
                    unique case (off)
                        u16550_pkg::OFF_DATA: dll_next = item.wdata;
                        u16550_pkg::OFF_IER:
                        begin
                            if (dlab)
                            begin
                                dlm_next = item.wdata;
                            end
                            else
                            begin
                                ier_next = item.wdata[3:0] & u16550_pkg::IER_MASK[3:0];
                                if (item.wdata[u16550_pkg::IER_THR] &&
                                    !ier_reg[u16550_pkg::IER_THR])
                                begin
                                    thre_next = 1'b1;
                                end
                            end
                        end
                        u16550_pkg::OFF_IIR:
                        begin
                            fifo_en_next = item.wdata[u16550_pkg::FCR_FIFO_ON];
                            if (item.wdata[u16550_pkg::FCR_RX_CLEAR])
                            begin
                                head_next = '0;
                                fill_next = '0;
                            end
                        end
                        u16550_pkg::OFF_LCR: lcr_next = item.wdata;
                        u16550_pkg::OFF_MCR: mcr_next = item.wdata;
                        u16550_pkg::OFF_SCR: scr_next = item.wdata;
                        default: ;
                    endcase
                end
            end
            u16550_pkg::CMD_READ:
            begin
                if (!in_window)
                begin
                    s1_result_next.port_error = 1'b1;
                end
                else
                begin
                    unique case (off)
                        u16550_pkg::OFF_DATA:
                        begin
                            if (dlab)
                            begin
                                s1_result_next.rdata = dll_reg;
                            end
                            else if (fill_reg != '0)
                            begin
                                pop         = 1'b1;
                                s1_pop_next = 1'b1;
                            end
                        end
                        u16550_pkg::OFF_IER:
                            s1_result_next.rdata = dlab ? dlm_reg : {4'h0, ier_reg};
                        u16550_pkg::OFF_IIR:
                        begin
                            s1_result_next.rdata = ident;
                            if (ident[3:0] == u16550_pkg::IIR_THR_EMPTY)
                            begin
                                thre_next = 1'b0;
                            end
                        end
                        u16550_pkg::OFF_LCR: s1_result_next.rdata = lcr_reg;
                        u16550_pkg::OFF_MCR: s1_result_next.rdata = mcr_reg;
                        u16550_pkg::OFF_LSR:
                            s1_result_next.rdata = u16550_pkg::LSR_TX_EMPTY |
                                                   {7'h0, (fill_reg != '0)};
                        u16550_pkg::OFF_MSR:
                        begin
                            // loopback maps out2, out1, dtr, rts onto dcd, ri, dsr, cts
                            if (mcr_reg[u16550_pkg::MCR_LB])
                            begin
                                s1_result_next.rdata = {mcr_reg[3], mcr_reg[2],
                                                        mcr_reg[0], mcr_reg[1], 4'h0};
                            end
                            else
                            begin
                                s1_result_next.rdata = u16550_pkg::MSR_IDLE;
                            end
                        end
                        u16550_pkg::OFF_SCR: s1_result_next.rdata = scr_reg;
                    endcase
                end
            end
            u16550_pkg::CMD_HOST_RX:
            begin
                if (fill_reg < FILL_W'(RX_DEPTH))
                begin
                    push                       = 1'b1;
                    s1_result_next.rx_accepted = 1'b1;
                end
            end
            u16550_pkg::CMD_UNUSED: ;
        endcase

        if (push)
        begin
            fill_next = fill_reg + 1'b1;
        end
        if (pop)
        begin
            fill_next = fill_reg - 1'b1;
            head_next = (head_reg == HEAD_W'(RX_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
    end

    // interrupt level recomputed from the updated state, held for out-of-window and unused items
    always_comb
    begin
        irq_pending = (ier_next[u16550_pkg::IER_RX] && (fill_next != '0)) ||
                      (ier_next[u16550_pkg::IER_THR] && thre_next);
        if ((item.cmd == u16550_pkg::CMD_HOST_RX) ||
            (((item.cmd == u16550_pkg::CMD_WRITE) || (item.cmd == u16550_pkg::CMD_READ)) &&
             in_window))
        begin
            irq_next = irq_pending && mcr_next[u16550_pkg::MCR_IRQ_GATE];
        end
        else
        begin
            irq_next = irq_reg;
        end
    end

    always_comb
    begin
        s1_result_irq         = s1_result_next;
        s1_result_irq.irq_out = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            fill_reg     <= '0;
            ier_reg      <= '0;
            fifo_en_reg  <= 1'b0;
            lcr_reg      <= '0;
            mcr_reg      <= '0;
            dll_reg      <= '0;
            dlm_reg      <= '0;
            scr_reg      <= '0;
            thre_reg     <= 1'b0;
            irq_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                head_reg    <= head_next;
                fill_reg    <= fill_next;
                ier_reg     <= ier_next;
                fifo_en_reg <= fifo_en_next;
                lcr_reg     <= lcr_next;
                mcr_reg     <= mcr_next;
                dll_reg     <= dll_next;
                dlm_reg     <= dlm_next;
                scr_reg     <= scr_next;
                thre_reg    <= thre_next;
                irq_reg     <= irq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pop_reg    <= s1_pop_next;
            s1_result_reg <= s1_result_irq;
        end
    end

    // a popped entry always comes from an earlier beat, so no bypass is needed
    u16550_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (accept && push),
        .wr_addr (tail),
        .wr_data (push_byte),
        .rd_en   (accept && pop),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        s1_result_full = s1_result_reg;
        if (s1_pop_reg)
        begin
            s1_result_full.rdata = ram_rd_data;
        end
    end

    u16550_out_queue u_out_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (s1_valid_reg),
        .push_data    (s1_result_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .level        (oq_level)
    );

endmodule

[test/tb_top.sv]
// self-checking testbench for the 16550a uart register model
`timescale 1ns / 100ps

module tb_top;

    localparam int RX_DEPTH        = 64;
    localparam int LOOP_FIFO_DEPTH = 16;
    localparam int BASE_PORT       = 1016;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    u16550_pkg::item_t   item         = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    u16550_pkg::result_t result;

    // shadow copy of the uart state
    logic [7:0] sh_rx_mem [RX_DEPTH];
    logic [5:0] sh_head    = '0;
    logic [6:0] sh_count   = '0;
    logic [3:0] sh_ier     = '0;
    logic       sh_fifo_on = 1'b0;
    logic [7:0] sh_lcr     = '0;
    logic [7:0] sh_mcr     = '0;
    logic [7:0] sh_dll     = '0;
    logic [7:0] sh_dlm     = '0;
    logic [7:0] sh_scr     = '0;
    logic       sh_thre    = 1'b0;
    logic       sh_irq     = 1'b0;

    u16550_pkg::result_t pending_results[$];

    int n_sent         = 0;
    int n_checked      = 0;
    int n_errors       = 0;
    int n_host_refused = 0;
    int n_loop_dropped = 0;
    int idle_pct       = 0;
    int stall_pct      = 0;
    int quiet_cycles   = 0;

    uart_16550a_register_model #(
        .RX_DEPTH        (RX_DEPTH),
        .LOOP_FIFO_DEPTH (LOOP_FIFO_DEPTH),
        .BASE_PORT       (BASE_PORT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] shadow_iir();
        logic [7:0] top;
        top = sh_fifo_on ? u16550_pkg::IIR_FIFO_BITS : 8'h00;
        if (sh_ier[u16550_pkg::IER_RX] && sh_count != 0)
            return top | {4'h0, u16550_pkg::IIR_RX_DATA};
        if (sh_ier[u16550_pkg::IER_THR] && sh_thre)
            return top | {4'h0, u16550_pkg::IIR_THR_EMPTY};
        return top | {4'h0, u16550_pkg::IIR_NONE};
    endfunction

    function automatic logic shadow_irq();
        logic [7:0] v;
        v = shadow_iir();
        return !v[0] && sh_mcr[u16550_pkg::MCR_IRQ_GATE];
    endfunction

    function automatic void shadow_push(logic [7:0] b);
        logic [5:0] tail;
        tail = sh_head + sh_count[5:0];
        sh_rx_mem[tail] = b;
        sh_count = sh_count + 7'd1;
    endfunction

    function automatic logic [7:0] shadow_read(logic [2:0] off);
        logic [7:0] v;
        logic       dlab;
        v = 8'h00;
        dlab = sh_lcr[u16550_pkg::LCR_DLAB];
        case (off)
            u16550_pkg::OFF_DATA:
                if (dlab)
                begin
                    v = sh_dll;
                end
                else if (sh_count != 0)
                begin
                    v = sh_rx_mem[sh_head];
                    sh_head = sh_head + 6'd1;
                    sh_count = sh_count - 7'd1;
                end
            u16550_pkg::OFF_IER: v = dlab ? sh_dlm : {4'h0, sh_ier};
            u16550_pkg::OFF_IIR:
            begin
                v = shadow_iir();
                // reading the thr-empty identification acknowledges it
                if (v[3:0] == u16550_pkg::IIR_THR_EMPTY)
                    sh_thre = 1'b0;
            end
            u16550_pkg::OFF_LCR: v = sh_lcr;
            u16550_pkg::OFF_MCR: v = sh_mcr;
            u16550_pkg::OFF_LSR: v = u16550_pkg::LSR_TX_EMPTY | {7'h0, sh_count != 0};
            u16550_pkg::OFF_MSR:
                if (sh_mcr[u16550_pkg::MCR_LB])
                    v = {sh_mcr[3], sh_mcr[2], sh_mcr[0], sh_mcr[1], 4'h0};
                else
                    v = u16550_pkg::MSR_IDLE;
            default: v = sh_scr;
        endcase
        return v;
    endfunction

    function automatic void shadow_write(logic [2:0] off, logic [7:0] d, logic first);
        logic dlab;
        dlab = sh_lcr[u16550_pkg::LCR_DLAB];
        if (off == u16550_pkg::OFF_DATA && !dlab)
        begin
            if (sh_mcr[u16550_pkg::MCR_LB])
            begin
                if (sh_count < LOOP_FIFO_DEPTH)
                    shadow_push(d);
                else
                    n_loop_dropped++;
            end
            sh_thre = 1'b1;
        end
        else if (first)
        begin
            case (off)
                u16550_pkg::OFF_DATA: sh_dll = d;
                u16550_pkg::OFF_IER:
                    if (dlab)
                    begin
                        sh_dlm = d;
                    end
                    else
                    begin
                        if (d[u16550_pkg::IER_THR] && !sh_ier[u16550_pkg::IER_THR])
                            sh_thre = 1'b1;
                        sh_ier = d[3:0] & u16550_pkg::IER_MASK[3:0];
                    end
                u16550_pkg::OFF_IIR:
                begin
                    sh_fifo_on = d[u16550_pkg::FCR_FIFO_ON];
                    if (d[u16550_pkg::FCR_RX_CLEAR])
                    begin
                        sh_head = '0;
                        sh_count = '0;
                    end
                end
                u16550_pkg::OFF_LCR: sh_lcr = d;
                u16550_pkg::OFF_MCR: sh_mcr = d;
                u16550_pkg::OFF_SCR: sh_scr = d;
                default: ;
            endcase
        end
    endfunction

    // expected result of one item, advancing the shadow state
    function automatic u16550_pkg::result_t uart_step(u16550_pkg::item_t it);
        u16550_pkg::result_t r;
        logic [2:0]          off;
        r = '0;
        if (it.cmd == u16550_pkg::CMD_WRITE || it.cmd == u16550_pkg::CMD_READ)
        begin
            if (it.port < BASE_PORT || it.port >= BASE_PORT + u16550_pkg::WINDOW_SIZE)
            begin
                r.port_error = 1'b1;
            end
            else
            begin
                off = 3'(it.port - BASE_PORT);
                if (it.cmd == u16550_pkg::CMD_WRITE)
                begin
                    if (off == u16550_pkg::OFF_DATA && !sh_lcr[u16550_pkg::LCR_DLAB] &&
                        !sh_mcr[u16550_pkg::MCR_LB])
                    begin
                        r.tx_valid = 1'b1;
                        r.tx_byte = it.wdata;
                    end
                    shadow_write(off, it.wdata, it.first_of_access);
                end
                else
                begin
                    r.rdata = shadow_read(off);
                end
                sh_irq = shadow_irq();
            end
        end
        else if (it.cmd == u16550_pkg::CMD_HOST_RX)
        begin
            if (sh_count < RX_DEPTH)
            begin
                shadow_push(it.wdata);
                r.rx_accepted = 1'b1;
            end
            else
            begin
                n_host_refused++;
            end
            sh_irq = shadow_irq();
        end
        r.irq_out = sh_irq;
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            n_errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // result beats are checked before the accepted item is predicted
    always @(posedge clk)
    begin
        u16550_pkg::result_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                n_errors++;
                $display("%0t: result beat with nothing expected, actual %h", $time, result);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("rdata", exp_r.rdata, result.rdata);
                check_field("tx_valid", 8'(exp_r.tx_valid), 8'(result.tx_valid));
                check_field("tx_byte", exp_r.tx_byte, result.tx_byte);
                check_field("irq_out", 8'(exp_r.irq_out), 8'(result.irq_out));
                check_field("port_error", 8'(exp_r.port_error), 8'(result.port_error));
                check_field("rx_accepted", 8'(exp_r.rx_accepted), 8'(result.rx_accepted));
                n_checked++;
            end
        end
        if (rst_n && item_valid && !item_stall)
            pending_results.push_back(uart_step(item));
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(negedge clk)
        result_stall <= rst_n && ($urandom_range(99) < stall_pct);

    // returns just after the edge that accepts the beat
    task automatic send_item(u16550_pkg::item_t it);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (item_stall);
        n_sent++;
    endtask

    task automatic send_raw(logic [1:0] c, logic [15:0] p, logic [7:0] d, logic f);
        u16550_pkg::item_t it;
        it = '{cmd: c, port: p, wdata: d, first_of_access: f};
        send_item(it);
    endtask

    task automatic bus_wr(logic [2:0] off, logic [7:0] d);
        send_raw(u16550_pkg::CMD_WRITE, 16'(BASE_PORT + off), d, 1'b1);
    endtask

    task automatic bus_rd(logic [2:0] off);
        send_raw(u16550_pkg::CMD_READ, 16'(BASE_PORT + off), 8'($urandom_range(255)), 1'b1);
    endtask

    task automatic host_byte(logic [7:0] d);
        send_raw(u16550_pkg::CMD_HOST_RX, 16'($urandom_range(65535)), d,
                 1'($urandom_range(1)));
    endtask

    // sender holds off until every outstanding result has come back
    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reset_values();
        bus_rd(u16550_pkg::OFF_IIR);
        bus_rd(u16550_pkg::OFF_LSR);
        bus_rd(u16550_pkg::OFF_MSR);
        bus_rd(u16550_pkg::OFF_DATA);
    endtask

    task automatic test_banked_registers();
        bus_wr(u16550_pkg::OFF_LCR, 8'h80);
        bus_wr(u16550_pkg::OFF_DATA, 8'hff);
        // later byte of a multi-byte write to dlm has no effect
        send_raw(u16550_pkg::CMD_WRITE, 16'(BASE_PORT + u16550_pkg::OFF_IER), 8'h55, 1'b0);
        bus_rd(u16550_pkg::OFF_IER);
        bus_rd(u16550_pkg::OFF_DATA);
        bus_wr(u16550_pkg::OFF_LCR, 8'h00);
        bus_wr(u16550_pkg::OFF_DATA, 8'hff);
        // later byte to thr still transmits
        send_raw(u16550_pkg::CMD_WRITE, 16'(BASE_PORT + u16550_pkg::OFF_DATA), 8'h00, 1'b0);
    endtask

    task automatic test_ident_priority();
        bus_wr(u16550_pkg::OFF_MCR, 8'h08);
        bus_wr(u16550_pkg::OFF_IER, 8'hff);
        host_byte(8'ha5);
        bus_rd(u16550_pkg::OFF_IIR);
        bus_rd(u16550_pkg::OFF_DATA);
        bus_rd(u16550_pkg::OFF_IIR);
        bus_wr(u16550_pkg::OFF_IIR, 8'h03);
        bus_rd(u16550_pkg::OFF_IIR);
    endtask

    task automatic test_window_and_unused();
        send_raw(u16550_pkg::CMD_READ, 16'(BASE_PORT - 1), 8'h00, 1'b1);
        send_raw(u16550_pkg::CMD_WRITE, 16'(BASE_PORT + u16550_pkg::WINDOW_SIZE), 8'hff,
                 1'b1);
        send_raw(u16550_pkg::CMD_READ, 16'h0000, 8'hff, 1'b0);
        send_raw(u16550_pkg::CMD_WRITE, 16'hffff, 8'h00, 1'b1);
        send_raw(u16550_pkg::CMD_UNUSED, 16'(BASE_PORT), 8'hff, 1'b1);
        bus_wr(u16550_pkg::OFF_LSR, 8'hff);
    endtask

    // mostly well-formed register sequences with random content, some noise
    task automatic test_random_traffic(int n_items);
        int         stop_at;
        int         n;
        logic [7:0] d;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    d = 8'($urandom_range(255));
                    if ($urandom_range(9) < 7)
                        send_raw(2'($urandom_range(3)), 16'(BASE_PORT + $urandom_range(7)),
                                 d, 1'($urandom_range(3) != 0));
                    else
                        send_raw(2'($urandom_range(3)), 16'($urandom_range(65535)),
                                 d, 1'($urandom_range(1)));
                end
                2, 3:
                begin
                    bus_wr(u16550_pkg::OFF_LCR, 8'h80 | 8'($urandom_range(255)));
                    bus_wr(u16550_pkg::OFF_DATA, 8'($urandom_range(255)));
                    bus_wr(u16550_pkg::OFF_IER, 8'($urandom_range(255)));
                    bus_rd(u16550_pkg::OFF_DATA);
                    bus_rd(u16550_pkg::OFF_IER);
                    bus_wr(u16550_pkg::OFF_LCR, 8'($urandom_range(127)));
                    bus_wr(u16550_pkg::OFF_IER, 8'($urandom_range(255)));
                    bus_wr(u16550_pkg::OFF_MCR, 8'($urandom_range(255)));
                    bus_rd(u16550_pkg::OFF_IIR);
                    bus_rd(u16550_pkg::OFF_MSR);
                end
                4, 5:
                begin
                    // now and then a long burst that can run the queue full
                    n = ($urandom_range(7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
                    repeat (n)
                        host_byte(8'($urandom_range(255)));
                    bus_wr(u16550_pkg::OFF_LCR, 8'($urandom_range(127)));
                    repeat ($urandom_range(n + 2))
                    begin
                        if ($urandom_range(3) == 0)
                            bus_rd($urandom_range(1) ? u16550_pkg::OFF_IIR
                                                     : u16550_pkg::OFF_LSR);
                        else
                            bus_rd(u16550_pkg::OFF_DATA);
                    end
                end
                6, 7, 8:
                begin
                    bus_wr(u16550_pkg::OFF_LCR, 8'($urandom_range(127)));
                    d = 8'($urandom_range(255));
                    d[u16550_pkg::MCR_LB] = 1'b1;
                    bus_wr(u16550_pkg::OFF_MCR, d);
                    n = $urandom_range(1, 20);
                    repeat (n)
                        send_raw(u16550_pkg::CMD_WRITE, 16'(BASE_PORT + u16550_pkg::OFF_DATA),
                                 8'($urandom_range(255)), 1'($urandom_range(1)));
                    bus_rd(u16550_pkg::OFF_MSR);
                    bus_rd(u16550_pkg::OFF_IIR);
                    repeat ($urandom_range(n + 1))
                        bus_rd(u16550_pkg::OFF_DATA);
                    bus_wr(u16550_pkg::OFF_MCR, 8'($urandom_range(255)) & 8'h0f);
                end
                default:
                begin
                    bus_wr(u16550_pkg::OFF_IIR, 8'($urandom_range(255)));
                    bus_rd(u16550_pkg::OFF_IIR);
                    bus_rd(u16550_pkg::OFF_LSR);
                    bus_wr(u16550_pkg::OFF_SCR, 8'($urandom_range(255)));
                    bus_rd(u16550_pkg::OFF_SCR);
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_banked_registers();
        test_ident_priority();
        test_window_and_unused();
        drain_results();

        test_random_traffic(120);
        drain_results();

        idle_pct = 60;
        stall_pct = 0;
        test_random_traffic(120);
        drain_results();

        idle_pct = 0;
        stall_pct = 60;
        test_random_traffic(120);
        drain_results();

        idle_pct = 36;
        stall_pct = 36;
        test_random_traffic(120);
        drain_results();

        repeat (8) @(posedge clk);
        $display("run covered %0d items in four idling phases, %0d results checked",
                 n_sent, n_checked);
        $display("host bytes refused at full queue: %0d, loopback bytes dropped: %0d",
                 n_host_refused, n_loop_dropped);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
